// File: design/olpi_pkg.sv
// Shared types and constants of the ordered list with positional insert.
// Used by olpi_cell, the top level and the port checker; depends on nothing.
package olpi_pkg;

   localparam int VALUE_W  = 32;
   localparam int POS_W    = 8;
   localparam int COUNT_W  = 9;

   // Command codes
   localparam logic [2:0] CMD_INS_FRONT = 3'd0;
   localparam logic [2:0] CMD_INS_BACK  = 3'd1;
   localparam logic [2:0] CMD_DEL_FRONT = 3'd2;
   localparam logic [2:0] CMD_DEL_BACK  = 3'd3;
   localparam logic [2:0] CMD_INS_POS   = 3'd4;

   // Status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_RANGE = 2'd3;

   typedef struct packed {
      logic [2:0]                command;
      logic signed [VALUE_W-1:0] value;
      logic [POS_W-1:0]          position;
   } req_type;

   typedef struct packed {
      logic [1:0]                status;
      logic signed [VALUE_W-1:0] removed_value;
      logic [COUNT_W-1:0]        entry_count;
   } rsp_type;

   // Broadcast from the decoder to every cell of the row
   typedef struct packed {
      logic                      ins_en;
      logic                      pop_en;
      logic [POS_W-1:0]          ins_at;
      logic signed [VALUE_W-1:0] value;
   } ctrl_type;

endpackage

// File: design/olpi_cell.sv
// One storage cell of the list row: holds one entry, loads, or shifts.
// Depends on olpi_pkg for the control broadcast type.
module olpi_cell
   import olpi_pkg::*;
#(
   parameter int INDEX = 0
) (
   input  logic                      clock,
   input  ctrl_type                  ctrl,
   input  logic signed [VALUE_W-1:0] left_data,
   input  logic signed [VALUE_W-1:0] right_data,
   output logic signed [VALUE_W-1:0] cell_data
);

   localparam logic [POS_W-1:0] MY_IDX = POS_W'(INDEX);

   logic signed [VALUE_W-1:0] data_ff;
   logic signed [VALUE_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.ins_en) begin
         // open the gap: cells behind the slot take from the front neighbor
         if (MY_IDX > ctrl.ins_at) begin
            data_in = left_data;
         end else if (MY_IDX == ctrl.ins_at) begin
            data_in = ctrl.value;
         end
      end else if (ctrl.pop_en) begin
         // close the gap: advance every entry one cell toward the front
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign cell_data = data_ff;

endmodule

// File: design/ordered_list_with_positional_insert.sv
// Ordered list with positional insert: top level, a row of olpi_cell and the output stage.
// Depends on olpi_pkg and olpi_cell.
//
// Holds up to CAPACITY signed 32-bit entries in a row of cells, front at cell 0.
// Every command beat on req_ is answered by exactly one beat on rsp_ carrying
// the status, the value removed by a successful delete (else zero) and the
// entry count after the command. The decoder works out from the count and the
// position which cells shift, load or hold, and all cells update together at the
// accepting edge, so one beat per cycle is sustained while req_stall is low. The
// result is registered in the output stage at the accepting edge. The output
// stage holds two results; req_stall rises only while both are waiting, so an
// item is taken even while one result sits stalled. Inserts into a full list report
// full and leave the list alone; a position beyond the count reports out of range,
// but an insert into an empty list goes to the front; deletes from an empty list
// report empty. Unused command codes report ok and change nothing. No clearing
// pass is needed after reset: cells past the count are never read.
module ordered_list_with_positional_insert
   import olpi_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   ctrl_type                  ctrl;
   logic signed [VALUE_W-1:0] cell_data [CAPACITY];
   logic signed [VALUE_W-1:0] back_val;
   logic [POS_W-1:0]          back_idx;
   logic                      accept;
   logic                      full;
   logic                      empty;
   rsp_type                   result;

   // output stage: main register plus one skid entry
   logic    out_valid_ff;
   logic    out_valid_in;
   rsp_type out_data_ff;
   rsp_type out_data_in;
   logic    skid_valid_ff;
   logic    skid_valid_in;
   rsp_type skid_data_ff;
   rsp_type skid_data_in;
   logic    take;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign take      = out_valid_ff && !rsp_stall;

   assign full     = (count_ff == CNT_W'(CAPACITY));
   assign empty    = (count_ff == '0);
   assign back_idx = POS_W'(count_ff - CNT_W'(1));

   // pick the back entry with a gated OR across the row
   always_comb begin
      back_val = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (POS_W'(i) == back_idx) begin
            back_val = back_val | cell_data[i];
         end
      end
   end

   // command decode: drive the cell broadcast, the result and the next count
   always_comb begin
      ctrl.ins_en = 1'b0;
      ctrl.pop_en = 1'b0;
      ctrl.ins_at = '0;
      ctrl.value  = req_data.value;
      result.status        = ST_OK;
      result.removed_value = '0;
      count_in             = count_ff;
      unique case (req_data.command) inside
         CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_POS: begin
            if (full) begin
               result.status = ST_FULL;
            end else if (req_data.command == CMD_INS_FRONT) begin
               ctrl.ins_en = accept;
            end else if (req_data.command == CMD_INS_BACK) begin
               ctrl.ins_en = accept;
               ctrl.ins_at = POS_W'(count_ff);
            end else if (req_data.position == '0 || empty) begin
               ctrl.ins_en = accept;
            end else if ({1'b0, req_data.position} > COUNT_W'(count_ff)) begin
               result.status = ST_RANGE;
            end else begin
               ctrl.ins_en = accept;
               ctrl.ins_at = req_data.position;
            end
            if (result.status == ST_OK) begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         CMD_DEL_FRONT: begin
            if (empty) begin
               result.status = ST_EMPTY;
            end else begin
               ctrl.pop_en          = accept;
               result.removed_value = cell_data[0];
               count_in             = count_ff - CNT_W'(1);
            end
         end
         CMD_DEL_BACK: begin
            if (empty) begin
               result.status = ST_EMPTY;
            end else begin
               result.removed_value = back_val;
               count_in             = count_ff - CNT_W'(1);
            end
         end
         default: begin
            // unused code: leave everything as it is
         end
      endcase
      result.entry_count = COUNT_W'(count_in);
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [VALUE_W-1:0] left_data;
      logic signed [VALUE_W-1:0] right_data;
      if (g == 0) begin : g_first
         assign left_data = req_data.value;
      end else begin : g_mid_l
         assign left_data = cell_data[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_mid_r
         assign right_data = cell_data[g+1];
      end
      olpi_cell #(
         .INDEX (g)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .left_data  (left_data),
         .right_data (right_data),
         .cell_data  (cell_data[g])
      );
   end

   // output stage next state
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || take) begin
         if (skid_valid_ff) begin
            // drain the skid entry first; no new beat is accepted meanwhile
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = accept;
            out_data_in  = result;
         end
      end else if (accept) begin
         // main register stalled: park the new result
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// File: design/olpi_checker.sv
// Port-level checks of the ordered list, bound to the top level.
// Depends on olpi_pkg and ordered_list_with_positional_insert.
module olpi_checker
   import olpi_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.entry_count <= COUNT_W'(CAPACITY))
      else $error("entry count beyond capacity");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_FULL |-> rsp_data.entry_count == COUNT_W'(CAPACITY))
      else $error("full status with room left");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_EMPTY
         |-> rsp_data.entry_count == '0 && rsp_data.removed_value == '0)
      else $error("empty status with entries or removed value");

   a_removed_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.removed_value != '0 |-> rsp_data.status == ST_OK)
      else $error("removed value on a failed command");

endmodule

bind ordered_list_with_positional_insert olpi_checker #(
   .CAPACITY (CAPACITY)
) u_olpi_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// File: bench/ordered_list_with_positional_insert_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for ordered_list_with_positional_insert: directed and random commands,
// a cycle-level list predictor and a field-by-field result checker.
// Depends on olpi_pkg and the ordered_list_with_positional_insert RTL.
module ordered_list_with_positional_insert_tb;
   import olpi_pkg::*;

   localparam int LIST_DEPTH   = 16;
   localparam int RANDOM_ITEMS = 1650;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;
   // Codes above the last defined command are decoded as no-ops.
   localparam logic [2:0] CMD_LAST_USED = CMD_INS_POS;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   ordered_list_with_positional_insert #(
      .CAPACITY (LIST_DEPTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Commands waiting to be driven, and the results the list owes us, oldest first.
   req_type pending_items[$];
   rsp_type owed_results[$];

   // Shadow of the list contents, front at index 0.
   logic signed [VALUE_W-1:0] shadow_cells[LIST_DEPTH];
   int shadow_count = 0;

   // Count the generator expects, so random positions can aim inside the list.
   int planned_count = 0;

   int  cycle_count    = 0;
   int  mismatch_count = 0;
   bit  req_beat_taken = 1'b0;
   int  send_wait      = 0;
   int  stall_hold     = 0;
   int  req_calm       = 0;
   int  rsp_calm       = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Pause length in cycles: mostly none or short, now and then long, and
   // occasionally a calm stretch during which no pause is drawn at all.
   function automatic int draw_pause(ref int calm_left);
      int roll;
      roll = $urandom_range(0, 99);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if (roll < 2) begin
         calm_left = $urandom_range(20, 80);
         return 0;
      end
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   // Apply one command to the shadow list and return the result it must produce.
   function automatic rsp_type apply_list_command(req_type beat);
      rsp_type outcome;
      int      slot;
      outcome.status        = ST_OK;
      outcome.removed_value = '0;
      slot                  = 0;
      case (beat.command)
         CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_POS: begin
            // Full wins over every other check, the position one included.
            if (shadow_count >= LIST_DEPTH) begin
               outcome.status = ST_FULL;
            end else begin
               if (beat.command == CMD_INS_BACK) begin
                  slot = shadow_count;
               end else if (beat.command == CMD_INS_POS && beat.position != 0
                            && shadow_count != 0) begin
                  slot = beat.position;
               end
               if (slot > shadow_count) begin
                  outcome.status = ST_RANGE;
               end else begin
                  // Open a gap at the slot and drop the value in.
                  for (int i = shadow_count; i > slot; i--)
                     shadow_cells[i] = shadow_cells[i-1];
                  shadow_cells[slot] = beat.value;
                  shadow_count++;
               end
            end
         end
         CMD_DEL_FRONT: begin
            if (shadow_count == 0) begin
               outcome.status = ST_EMPTY;
            end else begin
               outcome.removed_value = shadow_cells[0];
               for (int i = 1; i < shadow_count; i++)
                  shadow_cells[i-1] = shadow_cells[i];
               shadow_count--;
            end
         end
         CMD_DEL_BACK: begin
            if (shadow_count == 0) begin
               outcome.status = ST_EMPTY;
            end else begin
               shadow_count--;
               outcome.removed_value = shadow_cells[shadow_count];
            end
         end
         default: ;
      endcase
      outcome.entry_count = COUNT_W'(shadow_count);
      return outcome;
   endfunction

   // Queue one command and advance the planned count the same way the list would.
   task automatic push_item(logic [2:0] command, logic signed [VALUE_W-1:0] value,
                            logic [POS_W-1:0] position);
      req_type item;
      item.command  = command;
      item.value    = value;
      item.position = position;
      pending_items.push_back(item);
      case (command)
         CMD_INS_FRONT, CMD_INS_BACK: begin
            if (planned_count < LIST_DEPTH) planned_count++;
         end
         CMD_INS_POS: begin
            if (planned_count < LIST_DEPTH && (position == 0 || planned_count == 0
                                               || position <= planned_count))
               planned_count++;
         end
         CMD_DEL_FRONT, CMD_DEL_BACK: begin
            if (planned_count > 0) planned_count--;
         end
         default: ;
      endcase
   endtask

   // Sample at the rising edge: account for an accepted command beat, predict
   // its result, and check any result beat against the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("ordered_list_with_positional_insert_tb failed");
         $finish;
      end else begin
         req_beat_taken = !reset && req_valid && !req_stall;
         if (req_beat_taken)
            owed_results.push_back(apply_list_command(req_data));
         if (!reset && rsp_valid && !rsp_stall) begin
            got = rsp_data;
            if (owed_results.size() == 0) begin
               $error("result beat with no command outstanding: status %0d count %0d",
                      got.status, got.entry_count);
               mismatch_count++;
            end else begin
               want = owed_results.pop_front();
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  mismatch_count++;
               end
               if (got.removed_value !== want.removed_value) begin
                  $error("removed_value: expected %0d, got %0d",
                         want.removed_value, got.removed_value);
                  mismatch_count++;
               end
               if (got.entry_count !== want.entry_count) begin
                  $error("entry_count: expected %0d, got %0d",
                         want.entry_count, got.entry_count);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // Command driver: advance at the falling edge once the current beat has
   // been taken, or while the channel is idle. Hold the payload while stalled.
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_beat_taken)) begin
         if (req_valid) send_wait = draw_pause(req_calm);
         if (send_wait > 0) begin
            send_wait--;
            req_valid <= 1'b0;
         end else if (pending_items.size() != 0) begin
            req_data  <= pending_items.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result back-pressure: stall for a drawn number of cycles, then release
   // the stall before drawing again.
   always @(negedge clock) begin
      if (!reset) begin
         if (stall_hold > 0) begin
            stall_hold--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall  <= 1'b0;
            stall_hold = draw_pause(rsp_calm);
         end
      end
   end

   initial begin
      int                        trend;
      int                        ins_share;
      int                        roll;
      int                        pick;
      logic [2:0]                command;
      logic [POS_W-1:0]          position;
      logic signed [VALUE_W-1:0] value;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_stall = 1'b0;
      trend     = 0;
      ins_share = 50;

      // Directed part. Deletes on an empty list must report empty.
      push_item(CMD_DEL_FRONT, 32'sd0, 8'd0);
      push_item(CMD_DEL_BACK, -32'sd1, 8'hFF);
      // A positional insert into an empty list goes to the front.
      push_item(CMD_INS_POS, 32'sd17, 8'd5);
      push_item(CMD_INS_FRONT, 32'sh8000_0000, 8'hFF);
      push_item(CMD_INS_BACK, 32'sh7FFF_FFFF, 8'd0);
      push_item(CMD_INS_POS, -32'sd1, 8'd0);
      // Position equal to the count appends; beyond it is out of range.
      push_item(CMD_INS_POS, 32'sh5555_AAAA, POS_W'(planned_count));
      push_item(CMD_INS_POS, 32'sd3, POS_W'(planned_count + 1));
      push_item(CMD_INS_POS, 32'sd4, 8'hFF);
      // Unused codes are no-ops.
      for (int k = 1; k <= 3; k++)
         push_item(CMD_LAST_USED + 3'(k), $urandom, POS_W'($urandom_range(0, 255)));
      // Fill up with inserts into the middle.
      while (planned_count < LIST_DEPTH)
         push_item(CMD_INS_POS, $urandom, POS_W'(planned_count / 2));
      // Full takes precedence over the position check.
      push_item(CMD_INS_FRONT, 32'sd1, 8'd0);
      push_item(CMD_INS_BACK, 32'sd2, 8'd0);
      push_item(CMD_INS_POS, 32'sd3, 8'd200);
      push_item(CMD_DEL_FRONT, 32'sd0, 8'd0);
      push_item(CMD_DEL_BACK, 32'sd0, 8'd0);

      // Random part: phases that lean toward growing, shrinking or holding
      // steady, so the list swings between empty and full many times.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 50 == 0) begin
            trend     = $urandom_range(0, 2);
            ins_share = (trend == 0) ? 70 : (trend == 1) ? 25 : 47;
         end
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            command = CMD_LAST_USED + 3'($urandom_range(1, 3));
         end else if (roll < 3 + ins_share) begin
            pick = $urandom_range(0, 3);
            command = (pick == 0) ? CMD_INS_FRONT : (pick == 1) ? CMD_INS_BACK : CMD_INS_POS;
         end else begin
            command = ($urandom_range(0, 1) == 0) ? CMD_DEL_FRONT : CMD_DEL_BACK;
         end

         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            case ($urandom_range(0, 3))
               0:       value = 32'sh7FFF_FFFF;
               1:       value = 32'sh8000_0000;
               2:       value = 32'sd0;
               default: value = -32'sd1;
            endcase
         end else begin
            value = $urandom;
         end

         // Aim positional inserts mostly inside the list, some just past it.
         position = POS_W'($urandom_range(0, 255));
         if (command == CMD_INS_POS) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
               position = POS_W'($urandom_range(0, planned_count));
            else if (pick < 88)
               position = POS_W'($urandom_range(planned_count + 1, LIST_DEPTH + 2));
         end
         push_item(command, value, position);
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Drain: every command sent and every result back, then let a few more
      // cycles pass to catch any stray result beat.
      while (pending_items.size() != 0 || req_valid || owed_results.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && owed_results.size() == 0) begin
         $display("ordered_list_with_positional_insert_tb passed");
      end else begin
         $display("ordered_list_with_positional_insert_tb failed");
      end
      $finish;
   end

endmodule
